// ===== rtl/core/ara_pkg.sv =====
`timescale 1ns / 1ps

package ara_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_PAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_PERP = 2'd1;
    localparam logic [31:0] SIGMA_RESET = 32'h0001_0000;

    // item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic               final_pair;
    } ara_entry_t;

    typedef struct packed {
        logic       valid;
        ara_entry_t entry;
    } ara_q_t;

    typedef struct packed {
        logic [63:0] rem;
        logic        qb;
    } ara_div_t;

    typedef struct packed {
        logic [63:0] val;
        logic [63:0] root;
    } ara_sqrt_t;

    // one restoring division step; rem < den on entry
    function automatic ara_div_t ara_div_step(input logic [63:0] rem, input logic nb,
                                              input logic [63:0] den);
        logic [64:0] sh;
        ara_div_t    r;
        sh = {rem, nb};
        if (sh >= {1'b0, den}) begin
            r.rem = 64'(sh - {1'b0, den});
            r.qb  = 1'b1;
        end else begin
            r.rem = sh[63:0];
            r.qb  = 1'b0;
        end
        return r;
    endfunction

    // one digit-by-digit square root step
    function automatic ara_sqrt_t ara_sqrt_step(input logic [63:0] val,
                                                input logic [63:0] root,
                                                input logic [63:0] bitv);
        logic [63:0] trial;
        ara_sqrt_t   r;
        trial = root + bitv;
        if (val >= trial) begin
            r.val  = val - trial;
            r.root = (root >> 1) + bitv;
        end else begin
            r.val  = val;
            r.root = root >> 1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/ara_front.sv =====
`timescale 1ns / 1ps

module ara_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_first_x,
    input  logic signed [31:0]  s_first_y,
    input  logic signed [31:0]  s_first_z,
    input  logic signed [31:0]  s_second_x,
    input  logic signed [31:0]  s_second_y,
    input  logic signed [31:0]  s_second_z,
    input  logic signed [17:0]  s_normal_x,
    input  logic signed [17:0]  s_normal_y,
    input  logic signed [17:0]  s_normal_z,
    input  logic                s_final_pair,
    input  logic                q_pop,
    output ara_pkg::ara_q_t     q_out
);
    import ara_pkg::*;

    ara_entry_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    fill_reg;
    ara_entry_t         push_entry;
    logic               push;

    // differences are exact at 33 bits
    always_comb begin
        push_entry.dx         = 33'(s_first_x) - 33'(s_second_x);
        push_entry.dy         = 33'(s_first_y) - 33'(s_second_y);
        push_entry.dz         = 33'(s_first_z) - 33'(s_second_z);
        push_entry.nx         = s_normal_x;
        push_entry.ny         = s_normal_y;
        push_entry.nz         = s_normal_z;
        push_entry.final_pair = s_final_pair;
    end

    assign s_ready     = (fill_reg != (QPTR_W+1)'(QDEPTH));
    assign push        = s_valid && s_ready;
    assign q_out.valid = (fill_reg != '0);
    assign q_out.entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_entry;
                wr_ptr_reg          <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (!push && q_pop) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/ara_back.sv =====
`timescale 1ns / 1ps

module ara_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ara_pkg::ara_q_t    q_in,
    output logic               q_pop,
    input  logic [31:0]        sigma_par,
    input  logic [31:0]        sigma_perp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_residual_sum,
    output logic [31:0]        m_rms_error,
    output logic [31:0]        m_max_parallel,
    output logic [31:0]        m_max_perp,
    output logic [31:0]        m_pair_count
);
    import ara_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DOT, ST_PROJ, ST_SQ, ST_SIG, ST_DPREP, ST_DIV,
        ST_ACC, ST_RDIV, ST_ROOT, ST_SCALE, ST_OUT
    } state_t;

    localparam logic [63:0] ALL64 = '1;

    state_t             state_reg;
    logic [5:0]         step_reg;
    ara_entry_t         ent_reg;
    logic signed [52:0] dot_reg;
    logic signed [36:0] lam_reg;
    logic [39:0]        mag_reg [4];
    logic [81:0]        num_par_reg;
    logic [81:0]        num_perp_reg;
    logic [63:0]        den_a_reg;
    logic [63:0]        den_b_reg;
    logic [63:0]        rem_a_reg;
    logic [63:0]        rem_b_reg;
    logic [63:0]        lo_a_reg;
    logic [63:0]        lo_b_reg;
    logic [63:0]        q_a_reg;
    logic [63:0]        q_b_reg;
    logic               sat_a_reg;
    logic               sat_b_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        pk_par_reg;
    logic [63:0]        pk_perp_reg;
    logic [31:0]        cnt_reg;
    logic [63:0]        sv_reg   [3];
    logic [63:0]        sres_reg [3];
    logic [63:0]        sbit_reg;
    logic [63:0]        prod_par_reg;
    logic [63:0]        prod_perp_reg;
    logic               m_valid_reg;
    logic [63:0]        m_sum_reg;
    logic [31:0]        m_rms_reg;
    logic [31:0]        m_mpar_reg;
    logic [31:0]        m_mperp_reg;
    logic [31:0]        m_cnt_reg;

    // component select
    logic signed [32:0] sel_d;
    logic signed [17:0] sel_n;
    always_comb begin
        unique case (step_reg[1:0])
            2'd0: begin sel_d = ent_reg.dx; sel_n = ent_reg.nx; end
            2'd1: begin sel_d = ent_reg.dy; sel_n = ent_reg.ny; end
            2'd2: begin sel_d = ent_reg.dz; sel_n = ent_reg.nz; end
            default: begin sel_d = '0; sel_n = '0; end
        endcase
    end

    // dot product / projection
    logic signed [50:0] dot_prod;
    logic signed [52:0] dot_sum;
    logic signed [36:0] lam_new;
    logic [39:0]        lam_mag;
    logic signed [54:0] lam_n;
    logic signed [39:0] r_val;
    logic [39:0]        r_mag;

    assign dot_prod = sel_d * sel_n;
    assign dot_sum  = dot_reg + 53'(dot_prod);
    assign lam_new  = dot_sum[52:16];
    assign lam_mag  = 40'(lam_new[36] ? -lam_new : lam_new);
    assign lam_n    = lam_reg * sel_n;
    assign r_val    = 40'(sel_d) - 40'($signed(lam_n[54:16]));
    assign r_mag    = r_val[39] ? -r_val : r_val;

    // squares, two partial products each
    logic [39:0] sq_op;
    logic [31:0] sq_lo;
    logic [7:0]  sq_hi;
    logic [40:0] sq_mid;
    logic [63:0] pp_lo;
    logic [48:0] pp_hi;
    logic [81:0] sq_term;

    assign sq_op   = mag_reg[step_reg[2:1]];
    assign sq_lo   = sq_op[31:0];
    assign sq_hi   = sq_op[39:32];
    assign sq_mid  = {1'b0, sq_hi, 32'h0} + {8'h0, sq_lo, 1'b0};
    assign pp_lo   = sq_lo * sq_lo;
    assign pp_hi   = sq_hi * sq_mid;
    assign sq_term = step_reg[0] ? 82'({pp_hi, 32'h0}) : 82'(pp_lo);

    // divider steps; step a also serves the final sum/count division
    ara_div_t dstep_a;
    ara_div_t dstep_b;
    assign dstep_a = ara_div_step(rem_a_reg, lo_a_reg[63], den_a_reg);
    assign dstep_b = ara_div_step(rem_b_reg, lo_b_reg[63], den_b_reg);

    ara_sqrt_t rstep [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rstep[k] = ara_sqrt_step(sv_reg[k], sres_reg[k], sbit_reg);
        end
    end

    // accumulation
    logic [63:0] par2;
    logic [63:0] perp2;
    logic [64:0] inc_wide;
    logic [63:0] inc;
    logic [64:0] sum_wide;
    logic [63:0] sum_new;
    logic [31:0] cnt_new;

    assign par2     = sat_a_reg ? ALL64 : q_a_reg;
    assign perp2    = sat_b_reg ? ALL64 : q_b_reg;
    assign inc_wide = {1'b0, par2} + {1'b0, perp2};
    assign inc      = inc_wide[64] ? ALL64 : inc_wide[63:0];
    assign sum_wide = {1'b0, sum_reg} + {1'b0, inc};
    assign sum_new  = sum_wide[64] ? ALL64 : sum_wide[63:0];
    assign cnt_new  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    assign q_pop = (state_reg == ST_IDLE) && q_in.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            sum_reg     <= '0;
            pk_par_reg  <= '0;
            pk_perp_reg <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // ST_OUT reloads the result register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_in.valid) begin
                        ent_reg      <= q_in.entry;
                        dot_reg      <= '0;
                        num_par_reg  <= '0;
                        num_perp_reg <= '0;
                        step_reg     <= '0;
                        state_reg    <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    dot_reg <= dot_sum;
                    if (step_reg == 6'd2) begin
                        lam_reg    <= lam_new;
                        mag_reg[0] <= lam_mag;
                        step_reg   <= '0;
                        state_reg  <= ST_PROJ;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_PROJ: begin
                    mag_reg[2'(step_reg[1:0] + 2'd1)] <= r_mag;
                    if (step_reg == 6'd2) begin
                        step_reg  <= '0;
                        state_reg <= ST_SQ;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQ: begin
                    if (step_reg[2:1] == 2'd0) begin
                        num_par_reg <= num_par_reg + sq_term;
                    end else begin
                        num_perp_reg <= num_perp_reg + sq_term;
                    end
                    if (step_reg == 6'd7) begin
                        step_reg  <= '0;
                        state_reg <= ST_SIG;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SIG: begin
                    den_a_reg <= sigma_par * sigma_par;
                    den_b_reg <= sigma_perp * sigma_perp;
                    state_reg <= ST_DPREP;
                end
                ST_DPREP: begin
                    // numerator is the square shifted up by 32
                    rem_a_reg <= 64'(num_par_reg[81:32]);
                    lo_a_reg  <= {num_par_reg[31:0], 32'h0};
                    sat_a_reg <= (64'(num_par_reg[81:32]) >= den_a_reg);
                    rem_b_reg <= 64'(num_perp_reg[81:32]);
                    lo_b_reg  <= {num_perp_reg[31:0], 32'h0};
                    sat_b_reg <= (64'(num_perp_reg[81:32]) >= den_b_reg);
                    step_reg  <= 6'd63;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_a_reg <= dstep_a.rem;
                    q_a_reg   <= {q_a_reg[62:0], dstep_a.qb};
                    lo_a_reg  <= {lo_a_reg[62:0], 1'b0};
                    rem_b_reg <= dstep_b.rem;
                    q_b_reg   <= {q_b_reg[62:0], dstep_b.qb};
                    lo_b_reg  <= {lo_b_reg[62:0], 1'b0};
                    step_reg  <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    sum_reg <= sum_new;
                    cnt_reg <= cnt_new;
                    if (par2 > pk_par_reg) begin
                        pk_par_reg <= par2;
                    end
                    if (perp2 > pk_perp_reg) begin
                        pk_perp_reg <= perp2;
                    end
                    if (ent_reg.final_pair) begin
                        rem_a_reg <= '0;
                        lo_a_reg  <= sum_new;
                        den_a_reg <= 64'(cnt_new);
                        step_reg  <= 6'd63;
                        state_reg <= ST_RDIV;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RDIV: begin
                    rem_a_reg <= dstep_a.rem;
                    q_a_reg   <= {q_a_reg[62:0], dstep_a.qb};
                    lo_a_reg  <= {lo_a_reg[62:0], 1'b0};
                    step_reg  <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        sv_reg[0]   <= {q_a_reg[62:0], dstep_a.qb};
                        sv_reg[1]   <= pk_par_reg;
                        sv_reg[2]   <= pk_perp_reg;
                        sres_reg[0] <= '0;
                        sres_reg[1] <= '0;
                        sres_reg[2] <= '0;
                        sbit_reg    <= 64'h4000_0000_0000_0000;
                        step_reg    <= 6'd31;
                        state_reg   <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    for (int k = 0; k < 3; k++) begin
                        sv_reg[k]   <= rstep[k].val;
                        sres_reg[k] <= rstep[k].root;
                    end
                    sbit_reg <= sbit_reg >> 2;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    prod_par_reg  <= sres_reg[1][31:0] * sigma_par;
                    prod_perp_reg <= sres_reg[2][31:0] * sigma_perp;
                    state_reg     <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_sum_reg   <= sum_reg;
                        m_rms_reg   <= sres_reg[0][31:0];
                        m_mpar_reg  <= (prod_par_reg[63:48] != '0) ? '1
                                                                   : prod_par_reg[47:16];
                        m_mperp_reg <= (prod_perp_reg[63:48] != '0) ? '1
                                                                    : prod_perp_reg[47:16];
                        m_cnt_reg   <= cnt_reg;
                        sum_reg     <= '0;
                        pk_par_reg  <= '0;
                        pk_perp_reg <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_residual_sum = m_sum_reg;
    assign m_rms_error    = m_rms_reg;
    assign m_max_parallel = m_mpar_reg;
    assign m_max_perp     = m_mperp_reg;
    assign m_pair_count   = m_cnt_reg;

endmodule

// ===== rtl/core/anisotropic_residual_accumulator.sv =====
`timescale 1ns / 1ps

// Anisotropic point-pair residual accumulator. Each item is a point pair
// (Q16.16) with a normal (Q1.16); the block adds the squared distance along
// the normal over sigma_parallel^2 and across it over sigma_perp^2 to a
// saturating Q32.32 sum, tracks the peak of each term and counts pairs. The
// item flagged final_pair produces one result (sum, rms, scaled peaks,
// count) and clears the accumulated state. A two-entry queue takes items
// while the back end works; the back end handles one item at a time, and
// each item passes through 64-step bit-serial division that normalizes
// both terms. A final item adds another 64-step division for sum/count and
// 32-step square roots. sigma registers may be written only while the block
// is idle.
module anisotropic_residual_accumulator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ara_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_first_x,
    input  logic signed [31:0]                  s_first_y,
    input  logic signed [31:0]                  s_first_z,
    input  logic signed [31:0]                  s_second_x,
    input  logic signed [31:0]                  s_second_y,
    input  logic signed [31:0]                  s_second_z,
    input  logic signed [17:0]                  s_normal_x,
    input  logic signed [17:0]                  s_normal_y,
    input  logic signed [17:0]                  s_normal_z,
    input  logic                                s_final_pair,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [63:0]                         m_residual_sum,
    output logic [31:0]                         m_rms_error,
    output logic [31:0]                         m_max_parallel,
    output logic [31:0]                         m_max_perp,
    output logic [31:0]                         m_pair_count
);
    import ara_pkg::*;

    logic [31:0] sigma_par_reg;
    logic [31:0] sigma_perp_reg;
    ara_q_t      q_link;
    logic        q_pop;

    // config writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_par_reg  <= SIGMA_RESET;
            sigma_perp_reg <= SIGMA_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_SIGMA_PAR) begin
                sigma_par_reg <= cfg_data;
            end else if (cfg_index == REG_SIGMA_PERP) begin
                sigma_perp_reg <= cfg_data;
            end
        end
    end

    // front: differences and item queue
    ara_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_first_x    (s_first_x),
        .s_first_y    (s_first_y),
        .s_first_z    (s_first_z),
        .s_second_x   (s_second_x),
        .s_second_y   (s_second_y),
        .s_second_z   (s_second_z),
        .s_normal_x   (s_normal_x),
        .s_normal_y   (s_normal_y),
        .s_normal_z   (s_normal_z),
        .s_final_pair (s_final_pair),
        .q_pop        (q_pop),
        .q_out        (q_link)
    );

    // back: projection, normalization, accumulation, final result
    ara_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_in           (q_link),
        .q_pop          (q_pop),
        .sigma_par      (sigma_par_reg),
        .sigma_perp     (sigma_perp_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_residual_sum (m_residual_sum),
        .m_rms_error    (m_rms_error),
        .m_max_parallel (m_max_parallel),
        .m_max_perp     (m_max_perp),
        .m_pair_count   (m_pair_count)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_link.valid)
        else $error("back end popped an empty queue");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pair_count != '0))
        else $error("result with zero pair count");

    a_rms_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((64'(m_rms_error) * 64'(m_rms_error)) <= m_residual_sum))
        else $error("rms exceeds square root of sum");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ara_pkg::*;

    localparam int PERIOD     = 10;
    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake or register write
    localparam int SETTLE     = 200;    // settling pause at the end of each drain
    localparam int LONG_HOLD  = 700;    // receiver back-pressure stretch
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic               fin;
    } pair_t;

    typedef struct packed {
        logic [63:0] sum;
        logic [31:0] rms;
        logic [31:0] par;
        logic [31:0] perp;
        logic [31:0] count;
    } tally_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_first_x = '0, s_first_y = '0, s_first_z = '0;
    logic signed [31:0] s_second_x = '0, s_second_y = '0, s_second_z = '0;
    logic signed [17:0] s_normal_x = '0, s_normal_y = '0, s_normal_z = '0;
    logic s_final_pair = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_residual_sum;
    logic [31:0] m_rms_error, m_max_parallel, m_max_perp, m_pair_count;

    always #(PERIOD / 2) aclk = ~aclk;

    anisotropic_residual_accumulator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_x      (s_first_x),
        .s_first_y      (s_first_y),
        .s_first_z      (s_first_z),
        .s_second_x     (s_second_x),
        .s_second_y     (s_second_y),
        .s_second_z     (s_second_z),
        .s_normal_x     (s_normal_x),
        .s_normal_y     (s_normal_y),
        .s_normal_z     (s_normal_z),
        .s_final_pair   (s_final_pair),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_residual_sum (m_residual_sum),
        .m_rms_error    (m_rms_error),
        .m_max_parallel (m_max_parallel),
        .m_max_perp     (m_max_perp),
        .m_pair_count   (m_pair_count)
    );

    // ---------------------------------------------------------------
    // Predictor: own copy of the sigma registers and the accumulators
    // ---------------------------------------------------------------
    logic [31:0] sig_par = SIGMA_RESET;
    logic [31:0] sig_perp = SIGMA_RESET;
    logic [63:0] acc_sum = '0;
    logic [63:0] acc_peak_par = '0;
    logic [63:0] acc_peak_perp = '0;
    logic [31:0] acc_pairs = '0;

    pair_t  pending_pairs[$];
    tally_t expected_tallies[$];

    int errors = 0;
    int pairs_sent = 0;
    int tallies_checked = 0;
    bit burst_mode = 1'b0;      // no idling on either side while set
    int hold_left = 0;          // receiver hold-off, counted in the monitor

    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // exact square in Q.32 scaled to Q32.32 over sigma^2, truncated, saturated
    function automatic logic [63:0] normalize(input logic [127:0] sq, input logic [31:0] sig);
        logic [63:0]  den;
        logic [127:0] q;
        den = 64'(sig) * 64'(sig);
        if (den == 0)
            return '1;
        q = (sq << 32) / {64'd0, den};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [31:0] scale_peak(input logic [63:0] peak, input logic [31:0] sig);
        logic [63:0] p;
        p = (root64(peak) * 64'(sig)) >> 16;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    // fold one pair into the accumulators; returns 1 when a tally is due
    function automatic bit fold_pair(input pair_t p, output tally_t t);
        longint d[3];
        longint n[3];
        longint lam_full;
        longint lam;
        longint r;
        logic [127:0] perp_sq;
        logic [127:0] m;
        logic [63:0]  par2, perp2, inc;
        logic [64:0]  s;
        d[0] = longint'(p.fx) - longint'(p.sx);
        d[1] = longint'(p.fy) - longint'(p.sy);
        d[2] = longint'(p.fz) - longint'(p.sz);
        n[0] = longint'(p.nx);
        n[1] = longint'(p.ny);
        n[2] = longint'(p.nz);
        lam_full = 0;
        for (int i = 0; i < 3; i++)
            lam_full += d[i] * n[i];
        lam = lam_full >>> 16;
        perp_sq = '0;
        for (int i = 0; i < 3; i++) begin
            r = d[i] - ((lam * n[i]) >>> 16);
            m = {64'd0, mag64(r)};
            perp_sq += m * m;
        end
        m = {64'd0, mag64(lam)};
        par2 = normalize(m * m, sig_par);
        perp2 = normalize(perp_sq, sig_perp);
        s = {1'b0, par2} + {1'b0, perp2};
        inc = s[64] ? '1 : s[63:0];
        s = {1'b0, acc_sum} + {1'b0, inc};
        acc_sum = s[64] ? '1 : s[63:0];
        if (par2 > acc_peak_par)
            acc_peak_par = par2;
        if (perp2 > acc_peak_perp)
            acc_peak_perp = perp2;
        if (acc_pairs != 32'hFFFF_FFFF)
            acc_pairs++;
        t = '0;
        if (!p.fin)
            return 1'b0;
        t.sum = acc_sum;
        t.rms = 32'(root64(acc_sum / 64'(acc_pairs)));
        t.par = scale_peak(acc_peak_par, sig_par);
        t.perp = scale_peak(acc_peak_perp, sig_perp);
        t.count = acc_pairs;
        acc_sum = '0;
        acc_peak_par = '0;
        acc_peak_perp = '0;
        acc_pairs = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Driver: pops pending pairs, with a random idle gap (none in burst mode) per item
    // ---------------------------------------------------------------
    pair_t cur_pair;
    int send_gap = 0;

    always @(posedge aclk) begin
        tally_t t;
        bit     nv;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                if (fold_pair(cur_pair, t))
                    expected_tallies.push_back(t);
                pairs_sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_pairs.size() > 0) begin
                    cur_pair = pending_pairs.pop_front();
                    s_first_x    <= cur_pair.fx;
                    s_first_y    <= cur_pair.fy;
                    s_first_z    <= cur_pair.fz;
                    s_second_x   <= cur_pair.sx;
                    s_second_y   <= cur_pair.sy;
                    s_second_z   <= cur_pair.sz;
                    s_normal_x   <= cur_pair.nx;
                    s_normal_y   <= cur_pair.ny;
                    s_normal_z   <= cur_pair.nz;
                    s_final_pair <= cur_pair.fin;
                    nv = 1'b1;
                    send_gap = burst_mode ? 0 : $urandom_range(4);
                end
            end
            s_valid <= nv;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each tally against the oldest expectation
    // ---------------------------------------------------------------
    int recv_gap = 0;

    always @(posedge aclk) begin
        tally_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tallies.size() == 0) begin
                    $error("unexpected result: sum=%h count=%0d", m_residual_sum, m_pair_count);
                    errors++;
                end else begin
                    e = expected_tallies.pop_front();
                    tallies_checked++;
                    if (m_residual_sum !== e.sum) begin
                        $error("residual_sum: expected %h, got %h", e.sum, m_residual_sum);
                        errors++;
                    end
                    if (m_rms_error !== e.rms) begin
                        $error("rms_error: expected %h, got %h", e.rms, m_rms_error);
                        errors++;
                    end
                    if (m_max_parallel !== e.par) begin
                        $error("max_parallel: expected %h, got %h", e.par, m_max_parallel);
                        errors++;
                    end
                    if (m_max_perp !== e.perp) begin
                        $error("max_perp: expected %h, got %h", e.perp, m_max_perp);
                        errors++;
                    end
                    if (m_pair_count !== e.count) begin
                        $error("pair_count: expected %0d, got %0d", e.count, m_pair_count);
                        errors++;
                    end
                end
                recv_gap = burst_mode ? 0 : $urandom_range(4);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: any handshake or register write restarts the count
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", IDLE_LIMIT);
            $display("[anisotropic_residual_accumulator] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_SIGMA_PAR)
            sig_par = val;
        else if (idx == REG_SIGMA_PERP)
            sig_perp = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // everything sent, every tally back, then let the back end settle
    task automatic drain();
        wait (pending_pairs.size() == 0 && !s_valid && expected_tallies.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic signed [17:0] rand_normal();
        return 18'($signed($urandom_range(131072)) - 65536);
    endfunction

    function automatic logic signed [31:0] rand_coord(input int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
            default: return 32'($signed($urandom_range(1 << 13)) - (1 << 12));
        endcase
    endfunction

    task automatic push_pair(input logic signed [31:0] fx, fy, fz, sx, sy, sz,
                             input logic signed [17:0] nx, ny, nz, input logic fin);
        pair_t p;
        p = '{fx, fy, fz, sx, sy, sz, nx, ny, nz, fin};
        pending_pairs.push_back(p);
    endtask

    // one well-formed set of random pairs, final flag on the last one
    task automatic push_set(input int len);
        int style;
        logic signed [31:0] base;
        style = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
        for (int i = 0; i < len; i++) begin
            base = rand_coord(style);
            push_pair(rand_coord(style), rand_coord(style), base,
                      rand_coord(style), rand_coord(style), base + rand_coord(2),
                      rand_normal(), rand_normal(), rand_normal(), i == len - 1);
        end
    endtask

    task automatic random_phase(input int n_pairs);
        int left;
        int len;
        left = n_pairs;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
            if (len > left)
                len = left;
            push_set(len);
            left -= len;
        end
    endtask

    logic [31:0] sig_a[8];
    logic [31:0] sig_b[8];

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset sigmas (1.0)
        push_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        push_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  18'sh10000, 0, 0, 1'b1);
        push_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  -18'sh10000, -18'sh10000, -18'sh10000, 1'b1);
        // non-unit normal, and a multi-pair set that ends in a final pair
        push_pair(32'sh0003_0000, -32'sh0002_8000, 32'sh0000_0001,
                  0, 0, 0, 18'sh10000, 18'sh10000, 18'sh10000, 1'b0);
        push_pair(-32'sh0001_0000, 32'sh0000_4000, 32'sh0001_0000,
                  32'sh0001_0000, 0, -32'sh0000_0001, 18'sh0B505, -18'sh0B505, 0, 1'b0);
        push_pair(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000,
                  0, 0, 0, 0, 0, 18'sh10000, 1'b1);
        push_pair(32'sh1234_5678, 32'sh0000_0000, -32'sh0000_0100,
                  32'sh1234_5670, 32'sh0000_0010, 32'sh0000_0100,
                  -18'sh0FFFF, 18'sh00001, -18'sh00001, 1'b1);
        drain();

        // sigma at its smallest nonzero value: every term saturates for large deltas
        write_reg(REG_SIGMA_PAR, 32'd1);
        write_reg(REG_SIGMA_PERP, 32'd1);
        push_pair(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, 18'sh10000, 0, 0, 1'b0);
        push_pair(0, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 18'sh10000, 0, 0, 1'b0);
        push_pair(0, 0, 0, 0, 0, 32'sh0000_0001, 0, 0, 18'sh10000, 1'b1);
        drain();

        // sigma at its largest, plus writes to unmapped indexes
        write_reg(REG_SIGMA_PAR, 32'hFFFF_FFFF);
        write_reg(REG_SIGMA_PERP, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_LO, 32'h0000_0003);
        write_reg(REG_SPARE_HI, 32'hDEAD_BEEF);
        push_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  18'sh10000, -18'sh10000, 18'sh10000, 1'b0);
        push_pair(32'sh0001_0000, 0, 0, 0, 0, 0, 0, 18'sh10000, 0, 1'b1);
        drain();

        // random phases over several sigma settings
        sig_a = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 32'h0000_0100,
                  32'h0100_0000, 32'h0001_0000, 32'h0004_0000, 32'h0000_8000};
        sig_b = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd1, 32'h0003_0000,
                  32'h0000_4000, 32'h0001_0000, 32'h0000_0010, 32'h0002_0000};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph >= 5) begin
                write_reg(REG_SIGMA_PAR, sig_a[ph] ^ ($urandom & 32'h0000_FFFF) | 32'd1);
                write_reg(REG_SIGMA_PERP, sig_b[ph] ^ ($urandom & 32'h0000_FFFF) | 32'd1);
            end else begin
                write_reg(REG_SIGMA_PAR, sig_a[ph]);
                write_reg(REG_SIGMA_PERP, sig_b[ph]);
            end
            burst_mode = (ph == 3);
            if (ph == 2)
                hold_left = LONG_HOLD;  // block fills up while the driver keeps offering
            random_phase(110);
            drain();
        end
        burst_mode = 1'b0;

        $display("%0d pairs sent, %0d results checked over 11 sigma settings",
                 pairs_sent, tallies_checked);
        $display("covered saturation, extreme coordinates, non-unit normals, stalls");
        if (errors == 0)
            $display("[anisotropic_residual_accumulator] OK");
        else
            $display("[anisotropic_residual_accumulator] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ara_pkg.sv
rtl/core/ara_front.sv
rtl/core/ara_back.sv
rtl/core/anisotropic_residual_accumulator.sv
tb/testbench.sv
